>>> rtl/abds_pkg.sv
package abds_pkg;

    localparam int WaitW  = 24;
    localparam int BurnW  = 20;
    localparam int CountW = 8;
    localparam int TimerW = 24;
    localparam int CfgW   = 24;
    localparam int CfgIdxW = 2;

    localparam logic [WaitW-1:0]  WaitReset  = WaitW'(1000);
    localparam logic [BurnW-1:0]  BurnReset  = BurnW'(5000);
    localparam logic [CountW-1:0] MaxReset   = CountW'(3);
    localparam logic [WaitW-1:0]  PostReset  = WaitW'(60000);
    localparam logic [CountW-1:0] CountSat   = {CountW{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_BURN = 2'd2,
        PH_POST = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_DEPLOY = 2'd1,
        OP_FLAGS = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_WAIT  = 2'd0,
        CFG_BURN  = 2'd1,
        CFG_MAX   = 2'd2,
        CFG_POST  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [WaitW-1:0]  wait_ticks;
        logic [BurnW-1:0]  burn_ticks;
        logic [CountW-1:0] max_burns;
        logic [WaitW-1:0]  post_wait_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] op;
        logic       sense;
        logic       flag_deployed;
        logic       flag_birth;
    } t_item;

    typedef struct packed {
        logic              fire;
        logic              deployed;
        logic              birth_done;
        logic              busy_res;
        logic [1:0]        phase;
        logic [CountW-1:0] burns_done;
    } t_result;

endpackage

>>> rtl/antenna_burn_deploy_sequencer.sv
// Burn-wire antenna deployment sequencer. Each input beat is a tick, a deploy
// request or a write of the stored flags, and yields exactly one result beat
// holding the flags, phase, fire level and burn count after that beat. A beat
// sits in the input register, is folded into the sequencer state by one pass
// of combinational logic, and lands in the result register. One beat per cycle
// is sustained while i_ready holds no result back. Configuration writes
// take effect at once and are meant to happen while no beat is in flight.
module antenna_burn_deploy_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_op,
    input  logic                            i_sense,
    input  logic                            i_flag_deployed,
    input  logic                            i_flag_birth,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_fire,
    output logic                            o_deployed,
    output logic                            o_birth_done,
    output logic                            o_busy_res,
    output logic [1:0]                      o_phase,
    output logic [abds_pkg::CountW-1:0]     o_burns_done,
    input  logic                            i_cfg_we,
    input  logic [abds_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [abds_pkg::CfgW-1:0]       i_cfg_data
);
    import abds_pkg::*;

    t_cfg    r_cfg;
    t_item   r_item;
    logic    r_in_vld;
    t_result r_res;
    logic    r_out_vld;
    t_result step_res;
    logic    move;

    // input beat moves on when the result register is free or draining
    assign move    = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || move;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wait_ticks      <= WaitReset;
            r_cfg.burn_ticks      <= BurnReset;
            r_cfg.max_burns       <= MaxReset;
            r_cfg.post_wait_ticks <= PostReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WAIT: r_cfg.wait_ticks      <= i_cfg_data[WaitW-1:0];
                CFG_BURN: r_cfg.burn_ticks      <= i_cfg_data[BurnW-1:0];
                CFG_MAX:  r_cfg.max_burns       <= i_cfg_data[CountW-1:0];
                CFG_POST: r_cfg.post_wait_ticks <= i_cfg_data[WaitW-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.op            <= i_op;
            r_item.sense         <= i_sense;
            r_item.flag_deployed <= i_flag_deployed;
            r_item.flag_birth    <= i_flag_birth;
        end
    end

    // state update
    abds_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (move),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (move) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_res <= step_res;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_fire       = r_res.fire;
    assign o_deployed   = r_res.deployed;
    assign o_birth_done = r_res.birth_done;
    assign o_busy_res   = r_res.busy_res;
    assign o_phase      = r_res.phase;
    assign o_burns_done = r_res.burns_done;

    // a waiting input beat is never dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !move) |=> r_in_vld)
        else $error("input beat lost");

    // a stalled result beat is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |-> !move)
        else $error("result overwritten while stalled");

    // every beat moved forward shows up as a result
    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_vld)
        else $error("moved beat has no result");

endmodule

>>> rtl/abds_core.sv
module abds_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  abds_pkg::t_item   i_item,
    input  abds_pkg::t_cfg    i_cfg,
    output abds_pkg::t_result o_res
);
    import abds_pkg::*;

    t_phase              r_phase, n_phase;
    logic [TimerW-1:0]   r_timer, n_timer;
    logic [CountW-1:0]   r_count, n_count;
    logic                r_dep, n_dep;
    logic                r_birth, n_birth;

    logic                dep_s;
    logic [CountW-1:0]   cnt_inc;
    logic [TimerW-1:0]   len_wait, len_burn, len_post;

    // phase lengths, never below one tick
    always_comb begin
        len_wait = (i_cfg.wait_ticks == '0) ? TimerW'(1) : TimerW'(i_cfg.wait_ticks);
        len_burn = (i_cfg.burn_ticks == '0) ? TimerW'(1) : TimerW'(i_cfg.burn_ticks);
        len_post = (i_cfg.post_wait_ticks == '0) ? TimerW'(1)
                                                  : TimerW'(i_cfg.post_wait_ticks);
        cnt_inc  = (r_count == CountSat) ? r_count : r_count + CountW'(1);
    end

    // next state for one item
    always_comb begin
        dep_s   = r_dep | i_item.sense;
        n_phase = r_phase;
        n_timer = r_timer;
        n_count = r_count;
        n_dep   = dep_s;
        n_birth = r_birth;
        case (t_op'(i_item.op))
            OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (|r_timer[TimerW-1:1]) begin
                        n_timer = r_timer - TimerW'(1);
                    end else begin
                        case (r_phase)
                            PH_WAIT: begin
                                n_phase = PH_BURN;
                                n_timer = len_burn;
                            end
                            PH_BURN: begin
                                n_count = cnt_inc;
                                if (dep_s || cnt_inc >= i_cfg.max_burns) begin
                                    n_phase = PH_POST;
                                    n_timer = len_post;
                                end else begin
                                    n_phase = PH_WAIT;
                                    n_timer = len_wait;
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                n_timer = '0;
                                n_birth = 1'b1;
                            end
                        endcase
                    end
                end
            end
            OP_DEPLOY: begin
                if (r_phase == PH_IDLE) begin
                    if (!r_birth && !dep_s) begin
                        n_count = '0;
                        if (i_cfg.max_burns == '0) begin
                            n_phase = PH_POST;
                            n_timer = len_post;
                        end else begin
                            n_phase = PH_WAIT;
                            n_timer = len_wait;
                        end
                    end else begin
                        n_birth = 1'b1;
                    end
                end
            end
            OP_FLAGS: begin
                if (r_phase == PH_IDLE) begin
                    n_dep   = i_item.flag_deployed | i_item.sense;
                    n_birth = i_item.flag_birth;
                end
            end
            default: begin
            end
        endcase
    end

    // result fields follow the updated state
    always_comb begin
        o_res.fire       = (n_phase == PH_BURN);
        o_res.deployed   = n_dep;
        o_res.birth_done = n_birth;
        o_res.busy_res   = (n_phase != PH_IDLE);
        o_res.phase      = n_phase;
        o_res.burns_done = n_count;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_count <= '0;
            r_dep   <= 1'b0;
            r_birth <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_count <= n_count;
            r_dep   <= n_dep;
            r_birth <= n_birth;
        end
    end

    // idle holds a cleared timer, a running phase never a zero one
    a_idle_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_timer == '0))
        else $error("timer not clear while idle");

    a_busy_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_timer != '0))
        else $error("timer zero in a running phase");

    // once a burn is counted the count keeps its value until the next start
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_IDLE && t_op'(i_item.op) != OP_DEPLOY)
        |=> (r_count == $past(r_count)))
        else $error("burn count changed while idle");

    // a sequence only leaves post wait by setting first-boot done
    a_post_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_POST && n_phase == PH_IDLE && i_en) |=> r_birth)
        else $error("first-boot flag not set at end of sequence");

endmodule
